### rtl/tape_memory_bracket_match_assert.svh
// assertion macros shared by the tape block
`ifndef TAPE_MEMORY_BRACKET_MATCH_ASSERT_SVH
`define TAPE_MEMORY_BRACKET_MATCH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMBM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tape_memory_bracket_match: check failed");

// next-cycle implication, checked outside reset
`define TMBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tape_memory_bracket_match: check failed");

`endif

### rtl/tmbm_pkg.sv
package tmbm_pkg;

  // request codes
  localparam logic [2:0] REQ_GET   = 3'd0;
  localparam logic [2:0] REQ_SET   = 3'd1;
  localparam logic [2:0] REQ_INC   = 3'd2;
  localparam logic [2:0] REQ_DEC   = 3'd3;
  localparam logic [2:0] REQ_MATCH = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_UNMATCHED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_BRACKET = 2'd2;

  // bracket characters
  localparam logic [7:0] OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CLOSE_BRACKET = 8'h5D;

  // extent bounds, lo inclusive, hi exclusive
  typedef struct packed {
    logic signed [12:0] lo;
    logic signed [12:0] hi;
  } ext_bounds_t;

endpackage

### rtl/tape_memory_bracket_match.sv
// Byte tape with bracket matching. After reset the block runs a clearing pass over the
// tape memory with busy high. A request is taken when start is high and busy low; get,
// set, increment and decrement finish through the address and execute states, and so does
// a bracket match whose start cell is not a bracket or lies outside the extent. done
// pulses for one cycle with the result in the cycle in which the next start may already
// be taken. Any other bracket match goes on to scan cells until it finds the partner or
// reaches the extent edge: the scan reads the single tape memory one cell per cycle.
// The result stays on the outputs until the next request executes; done marks it for one
// cycle only and the receiver cannot hold it.
`include "tape_memory_bracket_match_assert.svh"

module tape_memory_bracket_match
  import tmbm_pkg::*;
#(
  parameter int TAPE_CELLS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [11:0] cell_index,
  input  logic [7:0]         write_value,
  output logic               done,
  output logic [7:0]         cell_value,
  output logic signed [11:0] match_index,
  output logic [1:0]         status
);

  localparam int AW = $clog2(TAPE_CELLS);
  localparam logic [AW-1:0] LastAddr = AW'(TAPE_CELLS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [AW-1:0]      clr_addr;
  logic               accept;

  logic [2:0]         req_q;
  logic signed [11:0] pos_q;
  logic [7:0]         wval_q;

  logic [AW-1:0]      map_addr;
  ext_bounds_t        bounds;
  logic               in_ext;
  logic               widen;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         rdata;

  logic [7:0]         exec_value;
  logic               exec_write;

  logic               fwd;
  logic signed [12:0] rd_pos;
  logic [AW-1:0]      rd_addr;
  logic signed [12:0] chk_pos;
  logic               chk_valid;
  logic [12:0]        depth;
  logic               hit;
  logic               can_issue;
  logic               is_open;
  logic               is_close;
  logic [AW-1:0]      addr_inc;
  logic [AW-1:0]      addr_dec;
  logic               result_clear;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  tmbm_addr_map #(
    .TAPE_CELLS(TAPE_CELLS)
  ) u_addr_map (
    .clk (clk),
    .load(accept),
    .pos (cell_index),
    .addr(map_addr)
  );

  tmbm_extent u_extent (
    .clk   (clk),
    .rst   (rst),
    .pos   (pos_q),
    .widen (widen),
    .bounds(bounds),
    .in_ext(in_ext)
  );

  tmbm_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_CELLS)
  ) u_tape (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  // cell update for get, set, increment, decrement
  always_comb begin
    exec_value = rdata;
    exec_write = 1'b0;
    case (req_q)
      REQ_SET: begin
        exec_value = wval_q;
        exec_write = 1'b1;
      end
      REQ_INC: begin
        exec_value = rdata + 8'd1;
        exec_write = 1'b1;
      end
      REQ_DEC: begin
        exec_value = rdata - 8'd1;
        exec_write = 1'b1;
      end
      default: begin
        exec_value = rdata;
        exec_write = 1'b0;
      end
    endcase
  end

  assign widen = (state == S_EXEC) && (req_q != REQ_MATCH);

  // memory port control; in execution a write and a read may address the same entry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = map_addr;
    mem_wdata = exec_value;
    mem_raddr = map_addr;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end else if (state == S_EXEC) begin
      mem_we = exec_write && (req_q != REQ_MATCH);
    end else if (state == S_SCAN) begin
      mem_raddr = rd_addr;
    end
  end

  // scan address stepping with wrap at the tape size
  assign addr_inc = (map_addr == LastAddr) ? '0 : map_addr + 1'b1;
  assign addr_dec = (map_addr == '0) ? LastAddr : map_addr - 1'b1;

  // scan check of the cell read last cycle
  always_comb begin
    is_open   = (rdata == OPEN_BRACKET);
    is_close  = (rdata == CLOSE_BRACKET);
    hit       = chk_valid && (depth == 13'd1) && (fwd ? is_close : is_open);
    can_issue = fwd ? (rd_pos < bounds.hi) : (rd_pos >= bounds.lo);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LastAddr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_ADDR;
      end
      S_ADDR: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (req_q == REQ_MATCH && in_ext && (is_open || is_close)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit || !can_issue) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC || state == S_SCAN) && (state_next == S_IDLE);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // request capture, scan state and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      pos_q  <= cell_index;
      wval_q <= write_value;
    end
    if (state == S_EXEC) begin
      fwd       <= is_open;
      rd_pos    <= is_open ? 13'(pos_q) + 13'sd1 : 13'(pos_q) - 13'sd1;
      rd_addr   <= is_open ? addr_inc : addr_dec;
      chk_valid <= 1'b0;
      depth     <= 13'd1;
      match_index <= 12'sd0;
      if (req_q != REQ_MATCH) begin
        cell_value <= exec_value;
        status     <= STATUS_OK;
      end else begin
        cell_value <= 8'd0;
        status     <= STATUS_NOT_BRACKET;
      end
    end
    if (state == S_SCAN) begin
      if (hit) begin
        match_index <= chk_pos[11:0];
        status      <= STATUS_OK;
      end else if (!can_issue) begin
        status <= STATUS_UNMATCHED;
      end else begin
        // depth update from the cell in hand, then the next read
        if (chk_valid) begin
          if (is_open) depth <= fwd ? depth + 13'd1 : depth - 13'd1;
          else if (is_close) depth <= fwd ? depth - 13'd1 : depth + 13'd1;
        end
        chk_pos   <= rd_pos;
        chk_valid <= 1'b1;
        rd_pos    <= fwd ? rd_pos + 13'sd1 : rd_pos - 13'sd1;
        if (fwd) rd_addr <= (rd_addr == LastAddr) ? '0 : rd_addr + 1'b1;
        else     rd_addr <= (rd_addr == '0) ? LastAddr : rd_addr - 1'b1;
      end
    end
  end

  // checks
  assign result_clear = (cell_value == 8'd0) && (match_index == 12'sd0);

  `TMBM_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `TMBM_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `TMBM_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `TMBM_ASSERT_IMP(a_fail_zero, clk, rst, done && (status != STATUS_OK), result_clear)

endmodule

### rtl/tmbm_ram.sv
module tmbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tmbm_addr_map.sv
module tmbm_addr_map #(
  parameter int TAPE_CELLS = 4096
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [11:0]            pos,
  output logic [$clog2(TAPE_CELLS)-1:0] addr
);

  localparam int AW = $clog2(TAPE_CELLS);
  // reciprocal of the tape size, exact for every 12-bit offset
  localparam int RecipShift = 30;
  localparam longint Recip = (64'd1 << RecipShift) / TAPE_CELLS + 1;
  localparam int RW = $clog2(Recip + 1);
  localparam int PW = 12 + RW;
  localparam logic [11:0] CellsLow = 12'(TAPE_CELLS);

  logic [11:0]   offset;
  logic [11:0]   offset_q;
  logic [PW-1:0] prod;
  logic [11:0]   quot;
  logic [11:0]   rem;

  // position + 2048 is the position with its sign bit flipped
  assign offset = {~pos[11], pos[10:0]};

  // stage one: offset times reciprocal
  always_ff @(posedge clk) begin
    if (load) begin
      offset_q <= offset;
      prod     <= PW'(offset) * PW'(Recip);
    end
  end

  // stage two: quotient back to remainder
  always_comb begin
    quot = 12'(prod >> RecipShift);
    rem  = offset_q - 12'(quot * CellsLow);
  end

  assign addr = AW'(rem);

endmodule

### rtl/tmbm_extent.sv
module tmbm_extent
  import tmbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [11:0] pos,
  input  logic               widen,
  output ext_bounds_t        bounds,
  output logic               in_ext
);

  logic signed [11:0] extent_low;
  logic        [12:0] extent_end;
  logic signed [11:0] extent_low_next;
  logic        [12:0] extent_end_next;
  logic signed [12:0] pos_w;
  logic signed [12:0] pos_p1;
  logic signed [12:0] lo_n;
  logic signed [12:0] hi_n;

  // current bounds and membership of the addressed cell
  always_comb begin
    pos_w     = 13'(pos);
    pos_p1    = pos_w + 13'sd1;
    bounds.lo = 13'(extent_low);
    bounds.hi = bounds.lo + signed'(extent_end);
    in_ext    = (pos_w >= bounds.lo) && (pos_w < bounds.hi);
  end

  // widened bounds covering the addressed cell
  always_comb begin
    lo_n = (pos_w < bounds.lo) ? pos_w : bounds.lo;
    hi_n = (pos_p1 > bounds.hi) ? pos_p1 : bounds.hi;
    extent_low_next = lo_n[11:0];
    extent_end_next = unsigned'(hi_n - lo_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_low <= 12'sd0;
      extent_end <= 13'd0;
    end else if (widen) begin
      extent_low <= extent_low_next;
      extent_end <= extent_end_next;
    end
  end

endmodule

### dv/tape_memory_bracket_match_tb.sv
module tape_memory_bracket_match_tb;
  import tmbm_pkg::*;

  localparam int TAPE_CELLS = 4096;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int SETTLE_CYCLES = 8;

  // request codes the block treats as get
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0]         cell_value;
    logic signed [11:0] match_index;
    logic [1:0]         status;
  } tape_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         req_type;
  logic signed [11:0] cell_index;
  logic [7:0]         write_value;
  logic               done;
  logic [7:0]         cell_value;
  logic signed [11:0] match_index;
  logic [1:0]         status;

  // shadow tape and extent
  logic [7:0] shadow_tape [TAPE_CELLS];
  int         shadow_lo;
  int         shadow_len;

  tape_result_t pending_results [$];
  tape_result_t oldest_result;

  int mismatch_count;
  int total_items;
  int match_paired;
  int match_unmatched;
  int match_not_bracket;
  int sender_idle_pct;
  int cycle_count;

  tape_memory_bracket_match #(
    .TAPE_CELLS(TAPE_CELLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .cell_index(cell_index),
    .write_value(write_value),
    .done(done),
    .cell_value(cell_value),
    .match_index(match_index),
    .status(status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int tape_slot(int pos);
    return (pos + 2048) % TAPE_CELLS;
  endfunction

  // expected outcome of one request, updating the shadow tape
  function automatic tape_result_t predict_tape_op(logic [2:0] req, logic signed [11:0] idx,
                                                   logic [7:0] wval);
    tape_result_t r;
    int pos;
    int p;
    int lo;
    int hi;
    int depth;
    int slot;
    logic [7:0] c;
    r = '0;
    pos = idx;
    if (req == REQ_MATCH) begin
      lo = shadow_lo;
      hi = shadow_lo + shadow_len;
      depth = 1;
      p = pos;
      if (pos < lo || pos >= hi) begin
        r.status = STATUS_NOT_BRACKET;
      end else if (shadow_tape[tape_slot(pos)] == OPEN_BRACKET) begin
        // forward scan to the extent end
        while (depth > 0 && p + 1 < hi) begin
          p++;
          c = shadow_tape[tape_slot(p)];
          if (c == OPEN_BRACKET) depth++;
          else if (c == CLOSE_BRACKET) depth--;
        end
        if (depth > 0) r.status = STATUS_UNMATCHED;
        else r.match_index = p[11:0];
      end else if (shadow_tape[tape_slot(pos)] == CLOSE_BRACKET) begin
        // backward scan to the extent start
        while (depth > 0 && p - 1 >= lo) begin
          p--;
          c = shadow_tape[tape_slot(p)];
          if (c == OPEN_BRACKET) depth--;
          else if (c == CLOSE_BRACKET) depth++;
        end
        if (depth > 0) r.status = STATUS_UNMATCHED;
        else r.match_index = p[11:0];
      end else begin
        r.status = STATUS_NOT_BRACKET;
      end
    end else begin
      // widen the extent to cover the cell
      lo = shadow_lo;
      hi = shadow_lo + shadow_len;
      if (pos < lo) lo = pos;
      if (pos + 1 > hi) hi = pos + 1;
      shadow_lo = lo;
      shadow_len = hi - lo;
      slot = tape_slot(pos);
      case (req)
        REQ_SET: shadow_tape[slot] = wval;
        REQ_INC: shadow_tape[slot] = shadow_tape[slot] + 8'd1;
        REQ_DEC: shadow_tape[slot] = shadow_tape[slot] - 8'd1;
        default: ;
      endcase
      r.cell_value = shadow_tape[slot];
    end
    return r;
  endfunction

  // one request transfer, with random sender idling ahead of it
  task automatic send_tape_op(logic [2:0] req, int idx, logic [7:0] wval);
    tape_result_t expected;
    @(negedge clk);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    cell_index <= idx[11:0];
    write_value <= wval;
    do @(posedge clk); while (busy);
    expected = predict_tape_op(req, idx[11:0], wval);
    pending_results = {pending_results, expected};
    total_items++;
    if (req == REQ_MATCH) begin
      if (expected.status == STATUS_OK) match_paired++;
      else if (expected.status == STATUS_UNMATCHED) match_unmatched++;
      else match_not_bracket++;
    end
  endtask

  // hold off new requests until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: cell_value %0d match_index %0d status %0d",
               cell_value, match_index, status);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (cell_value !== oldest_result.cell_value) begin
          $error("cell_value: expected %0d, actual %0d", oldest_result.cell_value, cell_value);
          mismatch_count++;
        end
        if (match_index !== oldest_result.match_index) begin
          $error("match_index: expected %0d, actual %0d",
                 $signed(oldest_result.match_index), match_index);
          mismatch_count++;
        end
        if (status !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d", oldest_result.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // matches on an empty extent and outside it, then a get
  task automatic test_empty_tape();
    send_tape_op(REQ_MATCH, 0, 8'h00);
    send_tape_op(REQ_MATCH, -2048, 8'hFF);
    send_tape_op(REQ_GET, 5, 8'h5A);
  endtask

  // wraparound of increment and decrement, spare codes as get
  task automatic test_cell_arith();
    send_tape_op(REQ_SET, 1, 8'hFF);
    send_tape_op(REQ_INC, 1, 8'h00);
    send_tape_op(REQ_DEC, 1, 8'hFF);
    send_tape_op(REQ_DEC, 2, 8'h00);
    send_tape_op(REQ_INC, 2, 8'hFF);
    send_tape_op(REQ_SPARE_LO, -3, 8'h00);
    send_tape_op(REQ_SPARE_HI, 1, 8'hFF);
  endtask

  // nested pairs, unmatched in both directions, non-bracket start
  task automatic test_bracket_cases();
    send_tape_op(REQ_SET, 10, OPEN_BRACKET);
    send_tape_op(REQ_SET, 11, OPEN_BRACKET);
    send_tape_op(REQ_SET, 12, CLOSE_BRACKET);
    send_tape_op(REQ_SET, 13, CLOSE_BRACKET);
    send_tape_op(REQ_MATCH, 10, 8'h00);
    send_tape_op(REQ_MATCH, 13, 8'h00);
    send_tape_op(REQ_MATCH, 11, 8'h00);
    send_tape_op(REQ_SET, 14, OPEN_BRACKET);
    send_tape_op(REQ_MATCH, 14, 8'h00);
    send_tape_op(REQ_SET, -4, CLOSE_BRACKET);
    send_tape_op(REQ_MATCH, -4, 8'h00);
    send_tape_op(REQ_MATCH, 3, 8'h00);
  endtask

  // mostly balanced bracket run written with sets, then probed by matches
  task automatic run_bracket_program();
    logic [7:0] cells [16];
    int base;
    int len;
    int depth;
    int roll;
    int i;
    base = int'($urandom_range(88)) - 48;
    len = $urandom_range(14, 2);
    depth = 0;
    for (i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      if (depth == len - i) begin
        cells[i] = CLOSE_BRACKET;
        depth--;
      end else if (roll < 40 && depth + 1 <= len - i - 1) begin
        cells[i] = OPEN_BRACKET;
        depth++;
      end else if (roll < 75 && depth > 0) begin
        cells[i] = CLOSE_BRACKET;
        depth--;
      end else begin
        cells[i] = 8'($urandom_range(255));
      end
    end
    // sometimes break the nesting
    if ($urandom_range(99) < 20)
      cells[$urandom_range(len - 1)] = $urandom_range(1) ? OPEN_BRACKET : CLOSE_BRACKET;
    for (i = 0; i < len; i++) send_tape_op(REQ_SET, base + i, cells[i]);
    repeat ($urandom_range(4, 1))
      send_tape_op(REQ_MATCH, base + int'($urandom_range(len + 1)) - 1,
                   8'($urandom_range(255)));
  endtask

  // bracket programs mixed with random requests near the origin
  task automatic test_random_programs();
    int first_item;
    first_item = total_items;
    while (total_items - first_item < ITEMS_PER_PHASE) begin
      if ($urandom_range(99) < 65)
        run_bracket_program();
      else
        send_tape_op(3'($urandom_range(7)), int'($urandom_range(127)) - 64,
                     8'($urandom_range(255)));
    end
  endtask

  // full-width extent and scans across the whole tape
  task automatic test_tape_extremes();
    send_tape_op(REQ_GET, -2048, 8'h00);
    send_tape_op(REQ_GET, 2047, 8'hFF);
    send_tape_op(REQ_SET, 2047, CLOSE_BRACKET);
    send_tape_op(REQ_SET, -2048, OPEN_BRACKET);
    send_tape_op(REQ_MATCH, -2048, 8'h00);
    send_tape_op(REQ_MATCH, 2047, 8'hFF);
    send_tape_op(REQ_SET, -2048, 8'h00);
    send_tape_op(REQ_MATCH, 2047, 8'h00);
    send_tape_op(REQ_INC, 2047, 8'h00);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_GET;
    cell_index = '0;
    write_value = '0;
    mismatch_count = 0;
    total_items = 0;
    match_paired = 0;
    match_unmatched = 0;
    match_not_bracket = 0;
    sender_idle_pct = 0;
    cycle_count = 0;
    shadow_lo = 0;
    shadow_len = 0;
    foreach (shadow_tape[k]) shadow_tape[k] = 8'h00;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_tape();
    test_cell_arith();
    test_bracket_cases();

    sender_idle_pct = 33;
    test_random_programs();
    wait_drained();
    sender_idle_pct = 88;
    test_random_programs();
    wait_drained();
    sender_idle_pct = 0;
    test_random_programs();

    test_tape_extremes();

    // drain and let the block settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("run covered %0d requests over three sender idling phases", total_items);
    $display("bracket matches: %0d paired, %0d unmatched, %0d on a non-bracket or off the extent",
             match_paired, match_unmatched, match_not_bracket);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tmbm_pkg.sv
rtl/tmbm_ram.sv
rtl/tmbm_addr_map.sv
rtl/tmbm_extent.sv
rtl/tape_memory_bracket_match.sv
dv/tape_memory_bracket_match_tb.sv
